>>> hw/rtl/sehm_pkg.sv
// Shared types and constants for the supercap energy health monitor.
package sehm_pkg;
   localparam int BLOCK_SAMPLES_DEF = 20;
   localparam int BAD_WINDOWS_DEF   = 3;
   localparam int VCAP_MAX_MV_DEF   = 28000;
   localparam int DERATE_MIN_MV_DEF = 20000;

   localparam logic [2:0] REG_ENERGY_GAIN    = 3'd0;
   localparam logic [2:0] REG_ANCHOR_MV      = 3'd1;
   localparam logic [2:0] REG_REARM_MV       = 3'd2;
   localparam logic [2:0] REG_ANCHOR_ENERGY  = 3'd3;
   localparam logic [2:0] REG_WINDOW_MS      = 3'd4;
   localparam logic [2:0] REG_MIN_EGAIN      = 3'd5;
   localparam logic [2:0] REG_MAX_VGAIN      = 3'd6;
   localparam logic [2:0] REG_DERATE_STEP    = 3'd7;

   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_TICK   = 1'b1;

   typedef struct packed {
      logic        command;
      logic [15:0] vcap_mv;
      logic [15:0] current_ma;
      logic [31:0] now_ms;
   } item_type;

   typedef struct packed {
      logic [31:0] energy_mj;
      logic        anchored;
      logic [15:0] vcap_max_mv;
      logic [7:0]  bad_windows;
      logic [15:0] derate_total;
      logic        unhealthy;
      logic [31:0] window_energy_gain_mj;
      logic [16:0] window_vcap_gain_mv;
   } result_type;
endpackage

>>> hw/rtl/sehm_front.sv
// Front end: accepts items and holds them in a short queue for the back end.
module sehm_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  sehm_pkg::item_type    in_item,
   output logic                  q_valid,
   input  logic                  q_take,
   output sehm_pkg::item_type    q_item
);
   sehm_pkg::item_type mem_ff [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       wp_ff, rp_ff;
   logic       push, pop;

   assign in_ready = (cnt_ff != 2'd2);
   assign push     = in_valid && in_ready;
   assign q_valid  = (cnt_ff != 2'd0);
   assign pop      = q_take && q_valid;
   assign q_item   = mem_ff[rp_ff];

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) cnt_in = cnt_ff + 2'd1;
      else if (pop && !push) cnt_in = cnt_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) wp_ff <= ~wp_ff;
         if (pop) rp_ff <= ~rp_ff;
      end
      if (push) mem_ff[wp_ff] <= in_item;
   end
endmodule

>>> hw/rtl/sehm_back.sv
// Back end: multi-cycle sample accumulate and tick energy/health update.
module sehm_back #(
   parameter int BLOCK_SAMPLES = sehm_pkg::BLOCK_SAMPLES_DEF,
   parameter int BAD_WINDOWS   = sehm_pkg::BAD_WINDOWS_DEF,
   parameter int VCAP_MAX_MV   = sehm_pkg::VCAP_MAX_MV_DEF,
   parameter int DERATE_MIN_MV = sehm_pkg::DERATE_MIN_MV_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [2:0]            csr_addr,
   input  logic [31:0]           csr_wdata,
   input  logic                  q_valid,
   output logic                  q_take,
   input  sehm_pkg::item_type    q_item,
   output logic                  out_valid,
   input  logic                  out_ready,
   output sehm_pkg::result_type  out_res
);
   typedef enum logic [3:0] {
      S_IDLE = 4'b0001, S_MUL = 4'b0010, S_ACC = 4'b0100, S_WIN = 4'b1000
   } state_type;

   localparam logic [7:0]  BLK_LIM = 8'(BLOCK_SAMPLES);
   localparam logic [7:0]  BAD_LIM = 8'(BAD_WINDOWS);
   localparam logic [16:0] VMAX    = 17'(VCAP_MAX_MV);
   localparam logic [16:0] VMIN    = 17'(DERATE_MIN_MV);

   state_type   st_ff, st_in;
   logic [15:0] gain_ff, anc_mv_ff, rearm_ff, win_ms_ff, step_ff;
   logic [30:0] anc_e_ff;
   logic [31:0] min_eg_ff;
   logic [16:0] max_vg_ff;

   sehm_pkg::item_type it_ff;
   logic signed [32:0] vi_ff;
   logic signed [63:0] prod_ff;
   logic [63:0] blk_ff, pend_ff, frac_ff;
   logic [7:0]  bcnt_ff, bad_ff;
   logic [31:0] en_ff, wst_ff, wse_ff, leg_ff;
   logic [16:0] wsv_ff, lvg_ff;
   logic [15:0] maxv_ff, dcnt_ff;
   logic        seen_ff, armed_ff, wval_ff, unh_ff, anch_ff;
   logic        ovalid_ff;

   logic        armed_n, fire;
   logic [63:0] s, mag;
   logic [31:0] en_n, eg;
   logic [16:0] vg, nxt;
   logic [7:0]  bad_n;
   logic        bad;

   assign q_take    = (st_ff == S_IDLE) && q_valid && !ovalid_ff;
   assign out_valid = ovalid_ff;
   assign out_res   = '{en_ff, anch_ff, maxv_ff, bad_ff, dcnt_ff, unh_ff, leg_ff, lvg_ff};

   always_comb begin
      armed_n = armed_ff;
      if (!seen_ff) armed_n = it_ff.vcap_mv < anc_mv_ff;
      else if (!armed_ff && it_ff.vcap_mv <= rearm_ff) armed_n = 1'b1;
      fire = armed_n && (it_ff.vcap_mv >= anc_mv_ff);
      s   = frac_ff + pend_ff;
      mag = 64'd0 - s;
      if (s[63]) en_n = en_ff - mag[63:32];
      else en_n = en_ff + s[63:32];
      eg  = en_ff - wse_ff;
      vg  = {1'b0, it_ff.vcap_mv} - wsv_ff;
      bad = ($signed(eg) >= $signed(min_eg_ff)) && ($signed(vg) < $signed(max_vg_ff));
      bad_n = bad ? ((bad_ff < BAD_LIM) ? bad_ff + 8'd1 : bad_ff) : 8'd0;
      nxt = {1'b0, maxv_ff} - {1'b0, step_ff};
      if ($signed(nxt) <= $signed(VMIN)) nxt = VMIN;
   end

   always_comb begin
      st_in = st_ff;
      case (st_ff)
         S_IDLE: if (q_take) st_in = S_MUL;
         S_MUL:  st_in = S_ACC;
         S_ACC:  st_in = (it_ff.command == sehm_pkg::CMD_TICK) ? S_WIN : S_IDLE;
         S_WIN:  st_in = S_IDLE;
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
         gain_ff <= 16'd215; anc_mv_ff <= 16'd20000; rearm_ff <= 16'd19000;
         anc_e_ff <= '0; win_ms_ff <= 16'd1000; min_eg_ff <= 32'd100;
         max_vg_ff <= 17'd100; step_ff <= 16'd500;
         blk_ff <= '0; pend_ff <= '0; frac_ff <= '0; bcnt_ff <= '0;
         en_ff <= '0; seen_ff <= 1'b0; armed_ff <= 1'b0; wval_ff <= 1'b0;
         wst_ff <= '0; wse_ff <= '0; wsv_ff <= '0; maxv_ff <= VMAX[15:0];
         bad_ff <= '0; dcnt_ff <= '0; unh_ff <= 1'b0; leg_ff <= '0; lvg_ff <= '0;
         anch_ff <= 1'b0; ovalid_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         if (out_valid && out_ready) ovalid_ff <= 1'b0;
         if (csr_we) begin
            case (csr_addr)
               sehm_pkg::REG_ENERGY_GAIN:   gain_ff   <= csr_wdata[15:0];
               sehm_pkg::REG_ANCHOR_MV:     anc_mv_ff <= csr_wdata[15:0];
               sehm_pkg::REG_REARM_MV:      rearm_ff  <= csr_wdata[15:0];
               sehm_pkg::REG_ANCHOR_ENERGY: anc_e_ff  <= csr_wdata[30:0];
               sehm_pkg::REG_WINDOW_MS:     win_ms_ff <= csr_wdata[15:0];
               sehm_pkg::REG_MIN_EGAIN:     min_eg_ff <= csr_wdata;
               sehm_pkg::REG_MAX_VGAIN:     max_vg_ff <= csr_wdata[16:0];
               sehm_pkg::REG_DERATE_STEP:   step_ff   <= csr_wdata[15:0];
               default: ;
            endcase
         end
         case (st_ff)
            S_IDLE: ;
            S_MUL: ;
            S_ACC: begin
               if (it_ff.command == sehm_pkg::CMD_SAMPLE) begin
                  if (bcnt_ff + 8'd1 >= BLK_LIM) begin
                     pend_ff <= pend_ff + blk_ff + 64'(prod_ff);
                     blk_ff  <= '0;
                     bcnt_ff <= '0;
                  end else begin
                     blk_ff  <= blk_ff + 64'(prod_ff);
                     bcnt_ff <= bcnt_ff + 8'd1;
                  end
                  anch_ff   <= 1'b0;
                  ovalid_ff <= 1'b1;
               end else begin
                  seen_ff <= 1'b1;
                  anch_ff <= fire;
                  pend_ff <= '0;
                  if (fire) begin
                     blk_ff <= '0; bcnt_ff <= '0; frac_ff <= '0;
                     en_ff <= {1'b0, anc_e_ff};
                     armed_ff <= 1'b0;
                  end else begin
                     armed_ff <= armed_n;
                     en_ff <= en_n;
                     frac_ff <= s[63] ? 64'd0 - {32'd0, mag[31:0]} : {32'd0, s[31:0]};
                  end
               end
            end
            S_WIN: begin
               ovalid_ff <= 1'b1;
               if (anch_ff || !wval_ff) begin
                  wval_ff <= 1'b1; wst_ff <= it_ff.now_ms; wse_ff <= en_ff;
                  wsv_ff <= {1'b0, it_ff.vcap_mv}; bad_ff <= '0;
               end else if ((it_ff.now_ms - wst_ff) >= {16'd0, win_ms_ff}) begin
                  leg_ff <= eg; lvg_ff <= vg;
                  if (bad_n >= BAD_LIM) begin
                     unh_ff <= 1'b1;
                     bad_ff <= '0;
                     if ({1'b0, maxv_ff} > VMIN && nxt < {1'b0, maxv_ff}) begin
                        maxv_ff <= nxt[15:0];
                        if (dcnt_ff != 16'hFFFF) dcnt_ff <= dcnt_ff + 16'd1;
                     end
                  end else bad_ff <= bad_n;
                  wst_ff <= it_ff.now_ms; wse_ff <= en_ff; wsv_ff <= {1'b0, it_ff.vcap_mv};
               end
            end
            default: ;
         endcase
      end
      if (q_take) begin
         it_ff <= q_item;
         vi_ff <= $signed({17'd0, q_item.vcap_mv}) * $signed(q_item.current_ma);
      end
      if (st_ff == S_MUL) prod_ff <= 64'(vi_ff * $signed({17'd0, gain_ff}));
   end
endmodule

>>> hw/rtl/supercap_energy_health_monitor_core.sv
// Top level of the supercap energy health monitor.
// Usage:
//  req_ channel carries sample items (command 0) and tick items (command 1).
//  rsp_ channel returns one result item per accepted item, in order.
//  csr_ port writes configuration registers 0..7; the user must write them
//  only while the block is idle, which the block itself does not enforce.
// Samples go through S_MUL and S_ACC (ticks also S_WIN) before rsp_tvalid rises;
//  the back end takes the next item only once the result is taken (multiply,
//  multiply-by-gain, accumulate/fold, window check).
// A two-entry queue decouples the req_ side from the back end; when the
//  receiver stalls the result holds in the output register and the queue
//  fills, then req_tready drops.
// Reset clears all sums, flags and counters; max voltage returns to
//  VCAP_MAX_MV and registers return to their reset values.
module supercap_energy_health_monitor_core #(
   parameter int BLOCK_SAMPLES = sehm_pkg::BLOCK_SAMPLES_DEF,
   parameter int BAD_WINDOWS   = sehm_pkg::BAD_WINDOWS_DEF,
   parameter int VCAP_MAX_MV   = sehm_pkg::VCAP_MAX_MV_DEF,
   parameter int DERATE_MIN_MV = sehm_pkg::DERATE_MIN_MV_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [63:0]  req_tdata,   // vcap_mv[15:0], current_ma[31:16], now_ms[63:32]
   input  logic         req_tuser,   // command
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // energy_mj, anchored, vcap_max_mv, bad_windows, derate_total, unhealthy,
   // window_energy_gain_mj, window_vcap_gain_mv; 32 bits, 1, 16, 8, 16, 1, 32, 17
   output logic [127:0] rsp_tdata,
   input  logic         csr_we,
   input  logic [2:0]   csr_addr,
   input  logic [31:0]  csr_wdata
);
   sehm_pkg::item_type   in_item, q_item;
   sehm_pkg::result_type res;
   logic q_valid, q_take;

   assign in_item = '{req_tuser, req_tdata[15:0], req_tdata[31:16], req_tdata[63:32]};
   assign rsp_tdata = {5'd0, res.window_vcap_gain_mv, res.window_energy_gain_mj,
                       res.unhealthy, res.derate_total, res.bad_windows,
                       res.vcap_max_mv, res.anchored, res.energy_mj};

   sehm_front u_front (
      .clock(clock), .reset(reset), .in_valid(req_tvalid), .in_ready(req_tready),
      .in_item(in_item), .q_valid(q_valid), .q_take(q_take), .q_item(q_item)
   );

   sehm_back #(
      .BLOCK_SAMPLES(BLOCK_SAMPLES), .BAD_WINDOWS(BAD_WINDOWS),
      .VCAP_MAX_MV(VCAP_MAX_MV), .DERATE_MIN_MV(DERATE_MIN_MV)
   ) u_back (
      .clock(clock), .reset(reset), .csr_we(csr_we), .csr_addr(csr_addr),
      .csr_wdata(csr_wdata), .q_valid(q_valid), .q_take(q_take), .q_item(q_item),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_res(res)
   );

`ifndef ASSERT_OFF
   a_anch_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[32]) |-> (rsp_tdata[31:0] == {1'b0, u_back.anc_e_ff}))
      else $error("anchored result without anchor energy");
   a_max_floor: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[48:33] <= 16'(VCAP_MAX_MV)))
      else $error("max voltage above ceiling");
   a_take_gap: assert property (@(posedge clock) disable iff (reset)
      q_take |=> !q_take)
      else $error("back end took items back to back");
`endif
endmodule
